// ===== sv/pgs_pkg.sv =====
// Shared types and constants for the PCM gain/saturate unit.
// No dependencies.
package pgs_pkg;

    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned GAIN_W   = 32;
    localparam int unsigned BYTES_W  = 3;
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN          = 2'd0,
        REG_SAMPLE_BYTES  = 2'd1,
        REG_LITTLE_ENDIAN = 2'd2
    } cfg_idx_t;

    localparam logic [BYTES_W-1:0] BYTES_2 = 3'd2;
    localparam logic [BYTES_W-1:0] BYTES_3 = 3'd3;
    localparam logic [BYTES_W-1:0] BYTES_4 = 3'd4;

    localparam logic [GAIN_W-1:0]  UNITY_GAIN      = 32'h0001_0000;
    localparam logic [BYTES_W-1:0] RST_SAMPLE_BYTES = BYTES_2;
    localparam logic               RST_LITTLE_ENDIAN = 1'b1;

    // Product clamp limits (symmetric).
    localparam logic signed [65:0] CLAMP_16 = 66'sh0_0000_0000_7fff_ffff;
    localparam logic signed [65:0] CLAMP_32 = 66'sh0_0000_7fff_ffff_ffff;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain;
        logic [BYTES_W-1:0] sample_bytes;
        logic               little_endian;
    } cfg_t;

endpackage

// ===== sv/pgs_cfg_regs.sv =====
// Configuration register file for the PCM gain/saturate unit.
// Depends on pgs_pkg.
module pgs_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pgs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pgs_pkg::SAMPLE_W-1:0]    cfg_data,
    output pgs_pkg::cfg_t                   cfg
);

    pgs_pkg::cfg_t cfg_reg;
    pgs_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                pgs_pkg::REG_GAIN:          cfg_next.gain = cfg_data;
                pgs_pkg::REG_SAMPLE_BYTES:
                    cfg_next.sample_bytes = cfg_data[pgs_pkg::BYTES_W-1:0];
                pgs_pkg::REG_LITTLE_ENDIAN: cfg_next.little_endian = cfg_data[0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain          <= pgs_pkg::UNITY_GAIN;
            cfg_reg.sample_bytes  <= pgs_pkg::RST_SAMPLE_BYTES;
            cfg_reg.little_endian <= pgs_pkg::RST_LITTLE_ENDIAN;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/pgs_scale.sv =====
// Combinational datapath: byte unpack, signed x unsigned 16.16 multiply,
// clamp, floor shift and byte repack. Depends on pgs_pkg.
module pgs_scale (
    input  pgs_pkg::cfg_t                   cfg,
    input  logic [pgs_pkg::SAMPLE_W-1:0]    sample,
    output logic [pgs_pkg::SAMPLE_W-1:0]    result
);

    logic [7:0]              b0, b1, b2, b3;
    logic [15:0]             raw16;
    logic [23:0]             raw24;
    logic [31:0]             raw32;
    logic signed [32:0]      opnd;
    logic signed [32:0]      gain_s;
    logic signed [65:0]      prod;
    logic signed [65:0]      lim;
    logic signed [65:0]      clamped;
    logic signed [47:0]      clamped48;
    logic signed [47:0]      sh16;
    logic signed [47:0]      sh24;
    logic                    bypass;
    logic                    le;

    assign b0 = sample[7:0];
    assign b1 = sample[15:8];
    assign b2 = sample[23:16];
    assign b3 = sample[31:24];
    assign le = cfg.little_endian;

    assign raw16 = le ? {b1, b0} : {b0, b1};
    assign raw24 = le ? {b2, b1, b0} : {b0, b1, b2};
    assign raw32 = le ? sample : {b0, b1, b2, b3};

    assign bypass = (cfg.gain == '0) || (cfg.gain == pgs_pkg::UNITY_GAIN);

    always_comb begin
        unique case (cfg.sample_bytes)
            pgs_pkg::BYTES_2: begin
                opnd = {{17{raw16[15]}}, raw16};
                lim  = pgs_pkg::CLAMP_16;
            end
            pgs_pkg::BYTES_3: begin
                opnd = {raw24[23], raw24, 8'h00};
                lim  = pgs_pkg::CLAMP_32;
            end
            default: begin
                opnd = {raw32[31], raw32};
                lim  = pgs_pkg::CLAMP_32;
            end
        endcase
    end

    assign gain_s = {1'b0, cfg.gain};
    assign prod   = opnd * gain_s;

    always_comb begin
        if (prod > lim) begin
            clamped = lim;
        end else if (prod < -lim) begin
            clamped = -lim;
        end else begin
            clamped = prod;
        end
    end

    assign clamped48 = clamped[47:0];
    assign sh16 = clamped48 >>> 16;
    assign sh24 = clamped48 >>> 24;

    always_comb begin
        if (bypass) begin
            result = sample;
        end else begin
            unique case (cfg.sample_bytes)
                pgs_pkg::BYTES_2:
                    result = le ? {16'h0000, sh16[15:0]}
                                : {16'h0000, sh16[7:0], sh16[15:8]};
                pgs_pkg::BYTES_3:
                    result = le ? {8'h00, sh24[23:0]}
                                : {8'h00, sh24[7:0], sh24[15:8], sh24[23:16]};
                pgs_pkg::BYTES_4:
                    result = le ? sh16[31:0]
                                : {sh16[7:0], sh16[15:8], sh16[23:16], sh16[31:24]};
                default:
                    result = sample;
            endcase
        end
    end

endmodule

// ===== sv/pcm_gain_saturate_unit.sv =====
// PCM sample gain with saturation: an accepted input request passes through the
// input register, then the result register, before its result is valid.
// Throughput one sample per cycle; the single 33x33 multiply sits between
// the two registers. Stalls on m_ready back-pressure only.
// Synchronous active-low reset clears valids; gain resets to 1.0,
// 16-bit little-endian samples. Depends on pgs_pkg, pgs_cfg_regs, pgs_scale.
module pcm_gain_saturate_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pgs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pgs_pkg::SAMPLE_W-1:0]    cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [pgs_pkg::SAMPLE_W-1:0]    s_sample_in,
    input  logic                            s_last_in,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [pgs_pkg::SAMPLE_W-1:0]    m_sample_out,
    output logic                            m_last_out
);

    pgs_pkg::cfg_t                 cfg;
    logic                          in_valid_reg;
    logic [pgs_pkg::SAMPLE_W-1:0]  in_sample_reg;
    logic                          in_last_reg;
    logic                          out_valid_reg;
    logic [pgs_pkg::SAMPLE_W-1:0]  out_sample_reg;
    logic                          out_last_reg;
    logic [pgs_pkg::SAMPLE_W-1:0]  out_sample_next;
    logic                          out_adv;

    pgs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pgs_scale u_scale (
        .cfg    (cfg),
        .sample (in_sample_reg),
        .result (out_sample_next)
    );

    assign out_adv = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || out_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_adv) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            in_sample_reg <= s_sample_in;
            in_last_reg   <= s_last_in;
        end
        if (out_adv) begin
            out_sample_reg <= out_sample_next;
            out_last_reg   <= in_last_reg;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_sample_out = out_sample_reg;
    assign m_last_out   = out_last_reg;

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for pcm_gain_saturate_unit: 16.16 gain with clamp on 2/3/4-byte PCM.
// Queue-fed driver and clocked monitor with random idles; predicts results in-bench.
// Depends on pgs_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        logic [pgs_pkg::SAMPLE_W-1:0] sample;
        logic                         last;
    } pcm_word_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    pgs_pkg::cfg_idx_t             cfg_index = pgs_pkg::REG_GAIN;
    logic [pgs_pkg::SAMPLE_W-1:0]  cfg_data = '0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [pgs_pkg::SAMPLE_W-1:0]  s_sample_in = '0;
    logic                          s_last_in = 1'b0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [pgs_pkg::SAMPLE_W-1:0]  m_sample_out;
    logic                          m_last_out;

    pcm_word_t      req_q[$];
    pcm_word_t      scaled_q[$];
    pcm_word_t      cur_req;
    pcm_word_t      want;
    pgs_pkg::cfg_t  cfg_now;
    bit             req_taken = 1'b0;
    bit             src_calm = 1'b0;
    bit             snk_calm = 1'b0;
    int             src_gap = 0;
    int             snk_stall = 0;
    int             n_bad = 0;
    int             n_checked = 0;
    int             n_settings = 0;
    int             n_cfg_writes = 0;
    int             n_random = 0;
    int             per_width[4] = '{0, 0, 0, 0};

    pcm_gain_saturate_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .s_last_in    (s_last_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .m_last_out   (m_last_out)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Memory byte order <-> numeric value; self-inverse, masks 2/3/4-byte samples to sample width.
    function automatic logic [31:0] byte_order(logic [31:0] v, pgs_pkg::cfg_t c);
        case (c.sample_bytes)
            pgs_pkg::BYTES_2: return c.little_endian ? {16'h0, v[15:0]}
                                                     : {16'h0, v[7:0], v[15:8]};
            pgs_pkg::BYTES_3: return c.little_endian ? {8'h0, v[23:0]}
                                                     : {8'h0, v[7:0], v[15:8], v[23:16]};
            pgs_pkg::BYTES_4: return c.little_endian ? v
                                                     : {v[7:0], v[15:8], v[23:16], v[31:24]};
            default: return v;
        endcase
    endfunction

    function automatic logic [31:0] scaled_sample(logic [31:0] x, pgs_pkg::cfg_t c);
        logic [31:0]        raw;
        logic signed [63:0] wide;
        logic signed [63:0] prod;
        logic signed [63:0] lim;
        logic signed [63:0] shifted;
        int unsigned        sh;
        if (c.gain == '0 || c.gain == pgs_pkg::UNITY_GAIN) return x;
        raw = byte_order(x, c);
        case (c.sample_bytes)
            pgs_pkg::BYTES_2: begin
                wide = {{48{raw[15]}}, raw[15:0]};
                lim  = pgs_pkg::CLAMP_16[63:0];
                sh   = 16;
            end
            pgs_pkg::BYTES_3: begin
                wide = {{32{raw[23]}}, raw[23:0], 8'h00};
                lim  = pgs_pkg::CLAMP_32[63:0];
                sh   = 24;
            end
            pgs_pkg::BYTES_4: begin
                wide = {{32{raw[31]}}, raw};
                lim  = pgs_pkg::CLAMP_32[63:0];
                sh   = 16;
            end
            default: return x;
        endcase
        prod = wide * $signed({32'h0, c.gain});
        if (prod > lim) prod = lim;
        else if (prod < -lim) prod = -lim;
        shifted = prod >>> sh;
        return byte_order(shifted[31:0], c);
    endfunction

    function automatic int idle_len(bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] random_gain();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 6))
                    0: return 32'h0;
                    1: return 32'h1;
                    2: return 32'h0000_ffff;
                    3: return pgs_pkg::UNITY_GAIN;
                    4: return 32'h0001_0001;
                    5: return 32'h8000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            1, 2, 3, 4: return $urandom_range(0, 32'h0003_ffff);
            5, 6: return $urandom_range(0, 32'h0000_ffff);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] random_sample(pgs_pkg::cfg_t c);
        int unsigned nbits;
        logic [31:0] v;
        nbits = (c.sample_bytes == pgs_pkg::BYTES_2) ? 16 :
                (c.sample_bytes == pgs_pkg::BYTES_3) ? 24 : 32;
        case ($urandom_range(0, 9))
            0: v = 32'hffff_ffff >> (33 - nbits);
            1: v = 32'h1 << (nbits - 1);
            2: v = 32'($urandom_range(0, 8)) - 32'd4;
            default: return $urandom();
        endcase
        v = byte_order(v, c);
        if (nbits < 32 && $urandom_range(0, 1) == 1)
            v = v | ($urandom() & (32'hffff_ffff << nbits));
        return v;
    endfunction

    task automatic queue_sample(logic [31:0] sample, logic last);
        req_q.push_back('{sample, last});
    endtask

    task automatic wait_idle();
        while (req_q.size() != 0 || s_valid || scaled_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(pgs_pkg::cfg_idx_t idx, logic [31:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            pgs_pkg::REG_GAIN:          cfg_now.gain = data;
            pgs_pkg::REG_SAMPLE_BYTES:  cfg_now.sample_bytes = data[pgs_pkg::BYTES_W-1:0];
            pgs_pkg::REG_LITTLE_ENDIAN: cfg_now.little_endian = data[0];
            default: ;
        endcase
        n_cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(logic [31:0] g, logic [pgs_pkg::BYTES_W-1:0] nb, logic le);
        wait_idle();
        write_reg(pgs_pkg::REG_GAIN, g);
        write_reg(pgs_pkg::REG_SAMPLE_BYTES, 32'(nb));
        write_reg(pgs_pkg::REG_LITTLE_ENDIAN, 32'(le));
        n_settings++;
    endtask

    // Request driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            req_taken = 1'b0;
            src_gap   = 0;
        end else if (!s_valid || req_taken) begin
            req_taken = 1'b0;
            if (src_gap > 0) begin
                src_gap--;
                s_valid <= 1'b0;
            end else if (req_q.size() != 0) begin
                cur_req = req_q.pop_front();
                s_valid     <= 1'b1;
                s_sample_in <= cur_req.sample;
                s_last_in   <= cur_req.last;
                src_gap = idle_len(src_calm);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result-side back-pressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            snk_stall = 0;
        end else if (snk_stall > 0) begin
            snk_stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!snk_calm && $urandom_range(0, 4) == 0) snk_stall = idle_len(1'b0);
        end
    end

    // Monitor: predict on accepted requests, check accepted results
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            scaled_q.push_back('{scaled_sample(s_sample_in, cfg_now), s_last_in});
            req_taken = 1'b1;
            case (cfg_now.sample_bytes)
                pgs_pkg::BYTES_2: per_width[0]++;
                pgs_pkg::BYTES_3: per_width[1]++;
                pgs_pkg::BYTES_4: per_width[2]++;
                default: per_width[3]++;
            endcase
        end
        if (aresetn && m_valid && m_ready) begin
            n_checked++;
            if (scaled_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("%0t: unexpected result sample=%h last=%b",
                             $time, m_sample_out, m_last_out);
            end else begin
                want = scaled_q.pop_front();
                if (m_sample_out !== want.sample || m_last_out !== want.last) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("%0t: mismatch sample exp %h got %h, last exp %b got %b",
                                 $time, want.sample, m_sample_out, want.last, m_last_out);
                end
            end
        end
    end

    initial begin
        int                          k;
        int                          cnt;
        logic [31:0]                 g;
        logic [pgs_pkg::BYTES_W-1:0] nb;
        logic                        le;

        cfg_now = '{gain: pgs_pkg::UNITY_GAIN, sample_bytes: pgs_pkg::RST_SAMPLE_BYTES,
                    little_endian: pgs_pkg::RST_LITTLE_ENDIAN};
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        n_settings = 1;

        // reset settings: unity gain passes all 32 bits
        queue_sample(32'hdead_beef, 1'b1);
        queue_sample(32'h0000_8000, 1'b0);

        // max gain, 16-bit LE: saturation both ways, stray upper bytes
        apply_setting(32'hffff_ffff, pgs_pkg::BYTES_2, 1'b1);
        queue_sample(32'h0000_7fff, 1'b0);
        queue_sample(32'h0000_8000, 1'b0);
        queue_sample(32'hffff_8001, 1'b0);
        queue_sample(32'h0000_0001, 1'b1);
        queue_sample(32'h0000_ffff, 1'b0);

        apply_setting(32'h8000_0000, pgs_pkg::BYTES_3, 1'b0);
        queue_sample(32'h00ff_ff7f, 1'b0);
        queue_sample(32'h0000_0080, 1'b1);
        queue_sample(32'hff00_0001, 1'b0);
        queue_sample(32'h00ff_ffff, 1'b0);

        apply_setting(32'h7fff_ffff, pgs_pkg::BYTES_4, 1'b1);
        queue_sample(32'h7fff_ffff, 1'b0);
        queue_sample(32'h8000_0000, 1'b0);
        queue_sample(32'hffff_ffff, 1'b1);
        queue_sample(32'h0000_0001, 1'b0);

        // smallest gain, 32-bit BE
        apply_setting(32'h0000_0001, pgs_pkg::BYTES_4, 1'b0);
        queue_sample(32'h0000_0080, 1'b0);
        queue_sample(32'hffff_ff7f, 1'b0);
        queue_sample(32'h1234_5678, 1'b1);

        // zero gain is bypass
        apply_setting(32'h0, pgs_pkg::BYTES_3, 1'b1);
        queue_sample(32'ha5c3_e1f0, 1'b0);

        // unsupported widths pass through
        apply_setting(32'h0001_8000, 3'd5, 1'b1);
        queue_sample(32'h8765_4321, 1'b1);
        apply_setting(32'h0002_8000, 3'd7, 1'b0);
        queue_sample(32'hffff_ffff, 1'b0);

        k = 0;
        while (n_random < 1500) begin
            g = random_gain();
            if (k < 6) begin
                nb = pgs_pkg::BYTES_2 + pgs_pkg::BYTES_W'(k / 2);
                le = k[0];
            end else begin
                nb = ($urandom_range(0, 11) == 0) ? pgs_pkg::BYTES_W'($urandom_range(0, 7))
                                                  : pgs_pkg::BYTES_W'($urandom_range(2, 4));
                le = $urandom_range(0, 1);
            end
            apply_setting(g, nb, le);
            src_calm = ($urandom_range(0, 3) == 0);
            snk_calm = ($urandom_range(0, 3) == 0);
            cnt = $urandom_range(50, 100);
            repeat (cnt) queue_sample(random_sample(cfg_now), $urandom_range(0, 7) == 0);
            n_random += cnt;
            k++;
        end

        while (req_q.size() != 0 || s_valid) @(posedge aclk);
        for (int w = 0; w < 5000 && scaled_q.size() != 0; w++) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (scaled_q.size() != 0) begin
            $display("%0d expected results never arrived", scaled_q.size());
            n_bad += scaled_q.size();
        end

        $display("Checked %0d samples across %0d register settings (%0d config writes)",
                 n_checked, n_settings, n_cfg_writes);
        $display("Samples by width 2/3/4/unsupported bytes: %0d/%0d/%0d/%0d, mismatches %0d",
                 per_width[0], per_width[1], per_width[2], per_width[3], n_bad);
        if (n_bad == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timeout with %0d requests queued, %0d results pending",
                 req_q.size(), scaled_q.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
